// ----- sv/bll_pkg.sv -----
// Shared types, constants and helpers of the binary-lifting ancestor block.
package bll_pkg;

    localparam int NODE_W      = 10;
    localparam int NODE_COUNT  = 1 << NODE_W;
    localparam int LIFT_LEVELS = 11;
    localparam int LVL_W       = $clog2(LIFT_LEVELS);
    localparam int TBL_AW      = LVL_W + NODE_W;
    localparam int TBL_DEPTH   = LIFT_LEVELS * NODE_COUNT;
    localparam int DIFF_W      = LIFT_LEVELS;

    localparam logic [NODE_W-1:0] NULL_NODE = NODE_W'(0);
    localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);
    localparam logic [LVL_W-1:0]  LVL_TOP   = LVL_W'(LIFT_LEVELS - 1);

    localparam logic MODE_ATTACH = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [10:0] {
        ST_CLR    = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_A_CHK  = 11'b000_0000_0100,
        ST_A_FILL = 11'b000_0000_1000,
        ST_Q_ORD  = 11'b000_0001_0000,
        ST_Q_UP1  = 11'b000_0010_0000,
        ST_Q_MID  = 11'b000_0100_0000,
        ST_Q_UP2  = 11'b000_1000_0000,
        ST_Q_FIN  = 11'b001_0000_0000,
        ST_Q_DEP  = 11'b010_0000_0000,
        ST_Q_OUT  = 11'b100_0000_0000
    } t_state;

    // One entry of the depth store: attached flag and depth.
    typedef struct packed {
        logic              att;
        logic [NODE_W-1:0] depth;
    } t_dep_ent;

    typedef struct packed {
        logic [NODE_W-1:0] rd0_addr;
        logic [NODE_W-1:0] rd1_addr;
        logic              we;
        logic [NODE_W-1:0] wr_addr;
        t_dep_ent          wr_data;
    } t_dep_req;

    typedef struct packed {
        logic [TBL_AW-1:0] rd_a_addr;
        logic [TBL_AW-1:0] rd_b_addr;
        logic              we;
        logic [TBL_AW-1:0] wr_addr;
        logic [NODE_W-1:0] wr_data;
    } t_tbl_req;

    typedef struct packed {
        logic              vld;
        logic [NODE_W-1:0] anc;
        logic [NODE_W-1:0] len;
    } t_res;

    // Table row layout: level in the upper bits, node in the lower bits.
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_W-1:0]  lvl,
                                                   input logic [NODE_W-1:0] node);
        return {lvl, node};
    endfunction

endpackage

// ----- sv/binary_lifting_lca_top.sv -----
// Top level of the binary-lifting lowest-common-ancestor block.
//
// Input channel (i_valid / o_stall): an item carries i_mode, i_node_a,
// i_node_b. Attach (mode 0) hangs node_b under node_a; it is dropped when
// node_b is 0 or already in the tree or node_a is not in the tree. Query
// (mode 1) asks for the lowest common ancestor of node_a and node_b.
// Output channel (o_valid / i_stall): one item per query, none per attach,
// with the ancestor node and the edge count of the path through it.
// Timing: an attach keeps the input stalled while it checks the nodes and,
// unless dropped, fills the new node's table row level by level. A query
// walks the ancestor table one level per cycle, first lifting the deeper
// node (11 levels) then both nodes (11 levels), so its result is loaded
// after both lifts (the first alone if the nodes meet). Each level is one
// dependent table read. No new item is taken until the sequencer is idle.
// Reset: synchronous, active low. After it a clearing pass rewrites every
// entry of the depth store (only the root marked present) with o_stall high.
// Output stall: the result waits in the output register; the next item is
// still taken, and a later query result waits in the sequencer until the
// output register frees up.
module binary_lifting_lca_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic [bll_pkg::NODE_W-1:0]  i_node_a,
    input  logic [bll_pkg::NODE_W-1:0]  i_node_b,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bll_pkg::NODE_W-1:0]  o_ancestor_node,
    output logic [bll_pkg::NODE_W-1:0]  o_path_length
);

    bll_pkg::t_dep_req          dep_req;
    bll_pkg::t_dep_ent          dep_q0, dep_q1;
    bll_pkg::t_tbl_req          tbl_req;
    logic [bll_pkg::NODE_W-1:0] tbl_q_a, tbl_q_b;
    bll_pkg::t_res              res;
    logic                       busy, load;

    logic                       r_out_valid;
    logic [bll_pkg::NODE_W-1:0] r_out_anc, r_out_len;

    bll_dep_mem u_dep_mem (
        .i_clk (i_clk),
        .i_req (dep_req),
        .o_q0  (dep_q0),
        .o_q1  (dep_q1)
    );

    bll_tbl_mem u_tbl_mem (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .o_q_a (tbl_q_a),
        .o_q_b (tbl_q_b)
    );

    bll_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_mode    (i_mode),
        .i_node_a  (i_node_a),
        .i_node_b  (i_node_b),
        .o_busy    (busy),
        .o_dep_req (dep_req),
        .i_dep_q0  (dep_q0),
        .i_dep_q1  (dep_q1),
        .o_tbl_req (tbl_req),
        .i_tbl_q_a (tbl_q_a),
        .i_tbl_q_b (tbl_q_b),
        .o_res     (res),
        .i_res_ack (load)
    );

    // output slot is free when empty or being taken this cycle
    assign load = res.vld && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_anc <= res.anc;
            r_out_len <= res.len;
        end
    end

    assign o_stall         = busy;
    assign o_valid         = r_out_valid;
    assign o_ancestor_node = r_out_anc;
    assign o_path_length   = r_out_len;

endmodule

// ----- sv/bll_dep_mem.sv -----
// Depth and attached-flag store: two registered read ports, one write port.
module bll_dep_mem (
    input  logic               i_clk,
    input  bll_pkg::t_dep_req  i_req,
    output bll_pkg::t_dep_ent  o_q0,
    output bll_pkg::t_dep_ent  o_q1
);

    bll_pkg::t_dep_ent mem [bll_pkg::NODE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        o_q0 <= mem[i_req.rd0_addr];
        o_q1 <= mem[i_req.rd1_addr];
    end

endmodule

// ----- sv/bll_tbl_mem.sv -----
// Ancestor table store: two registered read ports, one write port.
module bll_tbl_mem (
    input  logic                        i_clk,
    input  bll_pkg::t_tbl_req           i_req,
    output logic [bll_pkg::NODE_W-1:0]  o_q_a,
    output logic [bll_pkg::NODE_W-1:0]  o_q_b
);

    logic [bll_pkg::NODE_W-1:0] mem [bll_pkg::TBL_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        o_q_a <= mem[i_req.rd_a_addr];
        o_q_b <= mem[i_req.rd_b_addr];
    end

endmodule

// ----- sv/bll_seq.sv -----
// Sequencer: clearing pass, attach fill and the level-by-level query lift.
module bll_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_mode,
    input  logic [bll_pkg::NODE_W-1:0]  i_node_a,
    input  logic [bll_pkg::NODE_W-1:0]  i_node_b,
    output logic                        o_busy,
    output bll_pkg::t_dep_req           o_dep_req,
    input  bll_pkg::t_dep_ent           i_dep_q0,
    input  bll_pkg::t_dep_ent           i_dep_q1,
    output bll_pkg::t_tbl_req           o_tbl_req,
    input  logic [bll_pkg::NODE_W-1:0]  i_tbl_q_a,
    input  logic [bll_pkg::NODE_W-1:0]  i_tbl_q_b,
    output bll_pkg::t_res               o_res,
    input  logic                        i_res_ack
);

    bll_pkg::t_state r_state, n_state;

    logic [bll_pkg::NODE_W-1:0] r_a, n_a, r_b, n_b;
    logic                       r_ok_a, n_ok_a, r_ok_b, n_ok_b;
    logic [bll_pkg::LVL_W-1:0]  r_lvl, n_lvl;
    logic                       r_pend, n_pend;
    logic [bll_pkg::DIFF_W-1:0] r_diff, n_diff;
    logic [bll_pkg::NODE_W-1:0] r_sum, n_sum;
    logic [bll_pkg::NODE_W-1:0] r_anc, n_anc;
    logic [bll_pkg::NODE_W-1:0] r_len, n_len;
    logic [bll_pkg::NODE_W-1:0] r_clr, n_clr;

    // shared step unit
    logic [bll_pkg::NODE_W-1:0] cur_a, va, vb, g, na, nb;
    logic                       ok_cur, move, swap;

    // a row holds data only for an attached node other than the root
    function automatic logic row_ok(input logic [bll_pkg::NODE_W-1:0] n);
        return (n != bll_pkg::NULL_NODE) && (n != bll_pkg::ROOT_NODE);
    endfunction

    always_comb begin
        cur_a  = r_pend ? i_tbl_q_a : r_a;
        ok_cur = r_pend ? row_ok(i_tbl_q_a) : r_ok_a;
        va     = r_ok_a ? i_tbl_q_a : bll_pkg::NULL_NODE;
        vb     = r_ok_b ? i_tbl_q_b : bll_pkg::NULL_NODE;
        g      = va;
        move   = (va != bll_pkg::NULL_NODE) && (vb != bll_pkg::NULL_NODE) && (va != vb);
        na     = move ? va : r_a;
        nb     = move ? vb : r_b;
        swap   = i_dep_q0.depth < i_dep_q1.depth;
    end

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_ok_a  = r_ok_a;
        n_ok_b  = r_ok_b;
        n_lvl   = r_lvl;
        n_pend  = r_pend;
        n_diff  = r_diff;
        n_sum   = r_sum;
        n_anc   = r_anc;
        n_len   = r_len;
        n_clr   = r_clr;

        o_dep_req          = '0;
        o_dep_req.rd0_addr = i_node_a;
        o_dep_req.rd1_addr = i_node_b;
        o_dep_req.wr_addr  = r_clr;

        o_tbl_req           = '0;
        o_tbl_req.rd_a_addr = bll_pkg::tbl_addr(r_lvl, r_a);
        o_tbl_req.rd_b_addr = bll_pkg::tbl_addr(r_lvl, r_b);
        o_tbl_req.wr_addr   = bll_pkg::tbl_addr(r_lvl, r_b);

        o_res     = '0;
        o_res.anc = r_anc;
        o_res.len = r_len;

        case (r_state)
            bll_pkg::ST_CLR: begin
                o_dep_req.we            = 1'b1;
                o_dep_req.wr_data.att   = (r_clr == bll_pkg::ROOT_NODE);
                o_dep_req.wr_data.depth = '0;
                n_clr = r_clr + bll_pkg::NODE_W'(1);
                if (r_clr == bll_pkg::LAST_NODE) begin
                    n_state = bll_pkg::ST_IDLE;
                end
            end
            bll_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_a = i_node_a;
                    n_b = i_node_b;
                    n_state = (i_mode == bll_pkg::MODE_QUERY) ? bll_pkg::ST_Q_ORD
                                                              : bll_pkg::ST_A_CHK;
                end
            end
            bll_pkg::ST_A_CHK: begin
                if ((r_b == bll_pkg::NULL_NODE) || i_dep_q1.att || !i_dep_q0.att) begin
                    n_state = bll_pkg::ST_IDLE;
                end else begin
                    o_dep_req.we            = 1'b1;
                    o_dep_req.wr_addr       = r_b;
                    o_dep_req.wr_data.att   = 1'b1;
                    o_dep_req.wr_data.depth = bll_pkg::NODE_W'(i_dep_q0.depth +
                                                              bll_pkg::NODE_W'(1));
                    o_tbl_req.we        = 1'b1;
                    o_tbl_req.wr_addr   = bll_pkg::tbl_addr('0, r_b);
                    o_tbl_req.wr_data   = r_a;
                    o_tbl_req.rd_a_addr = bll_pkg::tbl_addr('0, r_a);
                    n_ok_a  = row_ok(r_a);
                    n_lvl   = bll_pkg::LVL_W'(1);
                    n_state = bll_pkg::ST_A_FILL;
                end
            end
            bll_pkg::ST_A_FILL: begin
                // entry (b, lvl) is the 2^(lvl-1) ancestor of entry (b, lvl-1)
                o_tbl_req.we        = 1'b1;
                o_tbl_req.wr_addr   = bll_pkg::tbl_addr(r_lvl, r_b);
                o_tbl_req.wr_data   = g;
                o_tbl_req.rd_a_addr = bll_pkg::tbl_addr(r_lvl, g);
                n_ok_a = row_ok(g);
                if (r_lvl == bll_pkg::LVL_TOP) begin
                    n_state = bll_pkg::ST_IDLE;
                end else begin
                    n_lvl = r_lvl + bll_pkg::LVL_W'(1);
                end
            end
            bll_pkg::ST_Q_ORD: begin
                n_a    = swap ? r_b : r_a;
                n_b    = swap ? r_a : r_b;
                n_ok_a = swap ? (i_dep_q1.att && (r_b != bll_pkg::ROOT_NODE))
                              : (i_dep_q0.att && (r_a != bll_pkg::ROOT_NODE));
                n_ok_b = swap ? (i_dep_q0.att && (r_a != bll_pkg::ROOT_NODE))
                              : (i_dep_q1.att && (r_b != bll_pkg::ROOT_NODE));
                n_diff = swap ? bll_pkg::DIFF_W'(i_dep_q1.depth - i_dep_q0.depth)
                              : bll_pkg::DIFF_W'(i_dep_q0.depth - i_dep_q1.depth);
                n_sum  = bll_pkg::NODE_W'(i_dep_q0.depth + i_dep_q1.depth);
                n_lvl  = bll_pkg::LVL_TOP;
                n_pend = 1'b0;
                n_state = bll_pkg::ST_Q_UP1;
            end
            bll_pkg::ST_Q_UP1: begin
                // deeper node climbs by the set bits of the depth difference
                n_a    = cur_a;
                n_ok_a = ok_cur;
                o_tbl_req.rd_a_addr = bll_pkg::tbl_addr(r_lvl, cur_a);
                n_pend = r_diff[r_lvl] && ok_cur;
                if (r_lvl == '0) begin
                    n_state = bll_pkg::ST_Q_MID;
                end else begin
                    n_lvl = r_lvl - bll_pkg::LVL_W'(1);
                end
            end
            bll_pkg::ST_Q_MID: begin
                n_a    = cur_a;
                n_ok_a = ok_cur;
                n_pend = 1'b0;
                if (cur_a == r_b) begin
                    n_anc = cur_a;
                    o_dep_req.rd0_addr = cur_a;
                    n_state = bll_pkg::ST_Q_DEP;
                end else begin
                    o_tbl_req.rd_a_addr = bll_pkg::tbl_addr(bll_pkg::LVL_TOP, cur_a);
                    o_tbl_req.rd_b_addr = bll_pkg::tbl_addr(bll_pkg::LVL_TOP, r_b);
                    n_lvl   = bll_pkg::LVL_TOP;
                    n_state = bll_pkg::ST_Q_UP2;
                end
            end
            bll_pkg::ST_Q_UP2: begin
                n_a    = na;
                n_b    = nb;
                n_ok_a = move ? row_ok(va) : r_ok_a;
                n_ok_b = move ? row_ok(vb) : r_ok_b;
                if (r_lvl == '0) begin
                    o_tbl_req.rd_a_addr = bll_pkg::tbl_addr('0, na);
                    n_state = bll_pkg::ST_Q_FIN;
                end else begin
                    o_tbl_req.rd_a_addr = bll_pkg::tbl_addr(r_lvl - bll_pkg::LVL_W'(1), na);
                    o_tbl_req.rd_b_addr = bll_pkg::tbl_addr(r_lvl - bll_pkg::LVL_W'(1), nb);
                    n_lvl = r_lvl - bll_pkg::LVL_W'(1);
                end
            end
            bll_pkg::ST_Q_FIN: begin
                n_anc = va;
                o_dep_req.rd0_addr = va;
                n_state = bll_pkg::ST_Q_DEP;
            end
            bll_pkg::ST_Q_DEP: begin
                n_len = bll_pkg::NODE_W'(r_sum -
                        {i_dep_q0.depth[bll_pkg::NODE_W-2:0], 1'b0});
                n_state = bll_pkg::ST_Q_OUT;
            end
            bll_pkg::ST_Q_OUT: begin
                o_res.vld = 1'b1;
                if (i_res_ack) begin
                    n_state = bll_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bll_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != bll_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bll_pkg::ST_CLR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_ok_a <= n_ok_a;
        r_ok_b <= n_ok_b;
        r_lvl  <= n_lvl;
        r_diff <= n_diff;
        r_sum  <= n_sum;
        r_anc  <= n_anc;
        r_len  <= n_len;
    end

endmodule

// ----- sv/bll_chk.sv -----
// Port-level checker for the binary-lifting ancestor block, with its bind.
module bll_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        i_mode,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [bll_pkg::NODE_W-1:0]  o_ancestor_node,
    input logic [bll_pkg::NODE_W-1:0]  o_path_length
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ancestor_node) &&
                               $stable(o_path_length))
        else $error("output item changed while stalled");

    // reset starts the clearing pass and empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("reset did not clear output or block input");

    // every accepted item keeps the sequencer busy in the cycle after it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while sequencer still free");

    // an attach never produces a result on its own
    a_attach_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_mode == bll_pkg::MODE_ATTACH) && !o_valid
        |=> !o_valid)
        else $error("result appeared after an attach item");

endmodule

bind binary_lifting_lca_top bll_chk u_bll_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_mode          (i_mode),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_ancestor_node (o_ancestor_node),
    .o_path_length   (o_path_length)
);
